/* hw/rtl/lifo_pkg.sv */
// Shared types for the bounded LIFO stack: command codes, result status, back-end states.
`timescale 1ns / 1ps
package lifo_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned CAP_W  = 5;
    localparam int unsigned FILL_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_PEEK   = 2'd2,
        OP_SEARCH = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_READ = 2'd1,
        S_SCAN = 2'd2
    } t_state;

    typedef struct packed {
        t_op                      op;
        logic signed [DATA_W-1:0] data;
    } t_cmd;

endpackage

/* hw/rtl/lifo_front.sv */
// Front end: accepts commands, decodes them and holds them in a two-entry queue.
`timescale 1ns / 1ps
module lifo_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [1:0]                        i_cmd,
    input  logic signed [lifo_pkg::DATA_W-1:0] i_data,
    output logic                              o_cq_valid,
    output lifo_pkg::t_cmd                    o_cq_cmd,
    input  logic                              i_cq_take
);

    lifo_pkg::t_cmd r_slot [2];
    logic           r_wr_ptr, n_wr_ptr;
    logic           r_rd_ptr, n_rd_ptr;
    logic [1:0]     r_cnt, n_cnt;
    logic           wr_en;
    logic           rd_en;
    lifo_pkg::t_cmd in_cmd;

    assign full       = (r_cnt == 2'd2);
    assign o_cq_valid = (r_cnt != 2'd0);
    assign o_cq_cmd   = r_slot[r_rd_ptr];

    assign wr_en = push && !full;
    assign rd_en = i_cq_take && o_cq_valid;

    always_comb begin
        in_cmd.op   = lifo_pkg::t_op'(i_cmd);
        in_cmd.data = i_data;
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ wr_en;
        n_rd_ptr = r_rd_ptr ^ rd_en;
        n_cnt    = r_cnt;
        if (wr_en && !rd_en) begin
            n_cnt = r_cnt + 2'd1;
        end else if (rd_en && !wr_en) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slot[r_wr_ptr] <= in_cmd;
        end
    end

endmodule

/* hw/rtl/lifo_back.sv */
// Back end: entry memory, fill count, capacity register, command sequencer and result register.
`timescale 1ns / 1ps
module lifo_back #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lifo_pkg::CAP_W-1:0]          i_cfg_data,
    input  logic                                i_cq_valid,
    input  lifo_pkg::t_cmd                      i_cq_cmd,
    output logic                                o_cq_take,
    output logic                                empty,
    input  logic                                pop,
    output logic [1:0]                          o_status,
    output logic signed [lifo_pkg::DATA_W-1:0]  o_value,
    output logic                                o_found,
    output logic [lifo_pkg::FILL_W-1:0]         o_fill_level
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned LW = (CW > lifo_pkg::CAP_W) ? CW : lifo_pkg::CAP_W;

    logic signed [lifo_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic signed [lifo_pkg::DATA_W-1:0] r_rd_data;

    lifo_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_idx, n_idx;
    logic [lifo_pkg::CAP_W-1:0] r_cap;
    logic signed [lifo_pkg::DATA_W-1:0] r_key, n_key;

    logic                               r_out_valid, n_out_valid;
    lifo_pkg::t_status                  r_status, n_status;
    logic signed [lifo_pkg::DATA_W-1:0] r_value, n_value;
    logic                               r_found, n_found;
    logic [CW-1:0]                      r_fill, n_fill;

    logic          start;
    logic          at_limit;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [CW-1:0] cnt_dec;
    logic [CW-1:0] cnt_inc;
    logic [LW-1:0] limit;
    logic [LW-1:0] cap_ext;
    logic [LW-1:0] fill_ext;
    logic          match;

    assign cap_ext  = LW'(r_cap);
    assign limit    = (cap_ext > LW'(DEPTH)) ? LW'(DEPTH) : cap_ext;
    assign at_limit = (LW'(r_count) >= limit);
    assign cnt_dec  = r_count - CW'(1);
    assign cnt_inc  = r_count + CW'(1);
    assign match    = (r_rd_data == r_key);

    // take a command only when the result register is free by the next edge
    assign start     = (r_state == lifo_pkg::S_IDLE) && i_cq_valid && (!r_out_valid || pop);
    assign o_cq_take = start;

    assign empty        = !r_out_valid;
    assign o_status     = r_status;
    assign o_value      = r_value;
    assign o_found      = r_found;
    assign fill_ext     = LW'(r_fill);
    assign o_fill_level = fill_ext[lifo_pkg::FILL_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_key       = r_key;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_value     = r_value;
        n_found     = r_found;
        n_fill      = r_fill;
        mem_we      = 1'b0;
        mem_waddr   = r_count[AW-1:0];
        rd_en       = 1'b0;
        rd_addr     = cnt_dec[AW-1:0];

        if (pop && r_out_valid) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            lifo_pkg::S_IDLE: begin
                if (start) begin
                    n_status = lifo_pkg::ST_DONE;
                    n_value  = '0;
                    n_found  = 1'b0;
                    n_fill   = r_count;
                    if (i_cq_cmd.op == lifo_pkg::OP_PUSH) begin
                        n_out_valid = 1'b1;
                        if (at_limit) begin
                            n_status = lifo_pkg::ST_FULL;
                        end else begin
                            mem_we  = 1'b1;
                            n_count = cnt_inc;
                            n_fill  = cnt_inc;
                        end
                    end else if (r_count == '0) begin
                        n_out_valid = 1'b1;
                        n_status    = lifo_pkg::ST_EMPTY;
                    end else begin
                        rd_en = 1'b1;
                        case (i_cq_cmd.op)
                            lifo_pkg::OP_POP: begin
                                n_count = cnt_dec;
                                n_state = lifo_pkg::S_READ;
                            end
                            lifo_pkg::OP_SEARCH: begin
                                rd_addr = '0;
                                n_idx   = CW'(1);
                                n_key   = i_cq_cmd.data;
                                n_state = lifo_pkg::S_SCAN;
                            end
                            default: begin
                                n_state = lifo_pkg::S_READ;
                            end
                        endcase
                    end
                end
            end
            lifo_pkg::S_READ: begin
                n_out_valid = 1'b1;
                n_value     = r_rd_data;
                n_fill      = r_count;
                n_state     = lifo_pkg::S_IDLE;
            end
            lifo_pkg::S_SCAN: begin
                if (match || (r_idx == r_count)) begin
                    n_out_valid = 1'b1;
                    n_found     = match;
                    n_fill      = r_count;
                    n_state     = lifo_pkg::S_IDLE;
                end else begin
                    // advance to the next live entry
                    rd_en   = 1'b1;
                    rd_addr = r_idx[AW-1:0];
                    n_idx   = r_idx + CW'(1);
                end
            end
            default: begin
                n_state = lifo_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lifo_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_cap       <= lifo_pkg::CAP_RESET;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_key    <= n_key;
        r_status <= n_status;
        r_value  <= n_value;
        r_found  <= n_found;
        r_fill   <= n_fill;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= i_cq_cmd.data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

`ifndef SYNTHESIS
    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count above depth");

    a_busy_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != lifo_pkg::S_IDLE) |-> !r_out_valid)
        else $error("result register occupied while a command is in flight");

    a_push_increments: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && (i_cq_cmd.op == lifo_pkg::OP_PUSH) && !at_limit)
        |=> (r_count == CW'($past(r_count) + CW'(1))))
        else $error("accepted push did not raise the fill count");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lifo_pkg::S_SCAN) |-> ((r_idx <= r_count) && (r_count != '0)))
        else $error("search index outside the live entries");
`endif

endmodule

/* hw/rtl/bounded_lifo_stack_with_search.sv */
// A push or a refused command shows its result in the cycle after it is accepted;
// pop and peek pass through S_READ first, for the registered read of the entry memory.
// One push or refused command is taken per cycle while the result side pops every result;
// pop and peek hold the back end in S_READ; a search steps the single read port in S_SCAN.
// Reset (synchronous, active low) empties the stack, command queue and result register and
// sets capacity to 16; entry memory is left as it is and never read above the fill level.
`timescale 1ns / 1ps
module bounded_lifo_stack_with_search #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lifo_pkg::CAP_W-1:0]          i_cfg_data,
    input  logic                                push,
    output logic                                full,
    input  logic [1:0]                          i_cmd,
    input  logic signed [lifo_pkg::DATA_W-1:0]  i_data,
    output logic                                empty,
    input  logic                                pop,
    output logic [1:0]                          o_status,
    output logic signed [lifo_pkg::DATA_W-1:0]  o_value,
    output logic                                o_found,
    output logic [lifo_pkg::FILL_W-1:0]         o_fill_level
);

    logic           cq_valid;
    lifo_pkg::t_cmd cq_cmd;
    logic           cq_take;

    lifo_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_cmd      (i_cmd),
        .i_data     (i_data),
        .o_cq_valid (cq_valid),
        .o_cq_cmd   (cq_cmd),
        .i_cq_take  (cq_take)
    );

    lifo_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_cq_valid   (cq_valid),
        .i_cq_cmd     (cq_cmd),
        .o_cq_take    (cq_take),
        .empty        (empty),
        .pop          (pop),
        .o_status     (o_status),
        .o_value      (o_value),
        .o_found      (o_found),
        .o_fill_level (o_fill_level)
    );

endmodule

/* tb/sv/bounded_lifo_stack_with_search_checker.sv */
// Checker for the bounded LIFO stack: predicts each result and compares it on the result side.
`timescale 1ns / 1ps
module bounded_lifo_stack_with_search_checker
    import lifo_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CAP_W-1:0]           i_cfg_data,
    input  logic                       push,
    input  logic                       full,
    input  logic [1:0]                 i_cmd,
    input  logic signed [DATA_W-1:0]   i_data,
    input  logic                       empty,
    input  logic                       pop,
    input  logic [1:0]                 o_status,
    input  logic signed [DATA_W-1:0]   o_value,
    input  logic                       o_found,
    input  logic [FILL_W-1:0]          o_fill_level,
    output int                         o_fail_count,
    output int                         o_pending_count
);

    localparam int unsigned STACK_DEPTH = 16;

    typedef struct {
        t_status                  status;
        logic signed [DATA_W-1:0] value;
        logic                     found;
        logic [FILL_W-1:0]        fill;
    } t_stack_result;

    logic [DATA_W-1:0] stack_words [STACK_DEPTH];
    int unsigned       stack_fill;
    logic [CAP_W-1:0]  capacity_reg;
    t_stack_result     expected_results [$];
    int                mismatches = 0;

    assign o_fail_count = mismatches;

    task automatic report_mismatch(string field, logic [DATA_W-1:0] want,
                                   logic [DATA_W-1:0] got);
        $display("%0t ns: stack result %s: expected %0h, got %0h", $time, field, want, got);
        mismatches++;
    endtask

    // Apply one command to the shadow stack and return the result it must produce.
    function automatic t_stack_result predict_stack(t_op op, logic [DATA_W-1:0] word);
        t_stack_result res;
        int unsigned   limit;
        res.status = ST_DONE;
        res.value  = '0;
        res.found  = 1'b0;
        limit = (capacity_reg > STACK_DEPTH) ? STACK_DEPTH : capacity_reg;
        if (op == OP_PUSH) begin
            if (stack_fill >= limit) begin
                res.status = ST_FULL;
            end else begin
                stack_words[stack_fill] = word;
                stack_fill++;
            end
        end else if (stack_fill == 0) begin
            res.status = ST_EMPTY;
        end else if (op == OP_POP) begin
            stack_fill--;
            res.value = stack_words[stack_fill];
        end else if (op == OP_PEEK) begin
            res.value = stack_words[stack_fill - 1];
        end else begin
            // only live entries count; slots above the fill level are stale
            for (int unsigned k = 0; k < stack_fill; k++)
                if (stack_words[k] == word) res.found = 1'b1;
        end
        res.fill = FILL_W'(stack_fill);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_stack_result want;
        if (!i_rst_n) begin
            stack_fill   = 0;
            capacity_reg = CAP_RESET;
            expected_results.delete();
        end else begin
            if (pop && !empty) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("with nothing pending, status", '0, DATA_W'(o_status));
                end else begin
                    want = expected_results.pop_front();
                    if (o_status !== want.status)
                        report_mismatch("status", DATA_W'(want.status), DATA_W'(o_status));
                    if (o_value !== want.value)
                        report_mismatch("value", want.value, o_value);
                    if (o_found !== want.found)
                        report_mismatch("found", DATA_W'(want.found), DATA_W'(o_found));
                    if (o_fill_level !== want.fill)
                        report_mismatch("fill_level", DATA_W'(want.fill),
                                        DATA_W'(o_fill_level));
                end
            end
            if (i_cfg_we) capacity_reg = i_cfg_data;
            if (push && !full) expected_results.push_back(predict_stack(t_op'(i_cmd), i_data));
        end
        o_pending_count <= expected_results.size();
    end

endmodule

/* tb/sv/bounded_lifo_stack_with_search_test.sv */
// Testbench top for the bounded LIFO stack: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps
module bounded_lifo_stack_with_search_test;
    import lifo_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 117;

    logic                      i_clk        = 1'b0;
    logic                      i_rst_n      = 1'b0;
    logic                      i_cfg_we     = 1'b0;
    logic [CAP_W-1:0]          i_cfg_data   = '0;
    logic                      push         = 1'b0;
    logic [1:0]                i_cmd        = OP_PUSH;
    logic signed [DATA_W-1:0]  i_data       = '0;
    logic                      pop          = 1'b0;
    logic                      full;
    logic                      empty;
    logic [1:0]                o_status;
    logic signed [DATA_W-1:0]  o_value;
    logic                      o_found;
    logic [FILL_W-1:0]         o_fill_level;
    int                        fail_count;
    int                        pending_count;
    int                        pop_hold     = 0;
    int                        quiet_cycles = 0;
    logic [DATA_W-1:0]         pushed_words [$];

    bounded_lifo_stack_with_search DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .push         (push),
        .full         (full),
        .i_cmd        (i_cmd),
        .i_data       (i_data),
        .empty        (empty),
        .pop          (pop),
        .o_status     (o_status),
        .o_value      (o_value),
        .o_found      (o_found),
        .o_fill_level (o_fill_level)
    );

    bounded_lifo_stack_with_search_checker checker_inst (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .push            (push),
        .full            (full),
        .i_cmd           (i_cmd),
        .i_data          (i_data),
        .empty           (empty),
        .pop             (pop),
        .o_status        (o_status),
        .o_value         (o_value),
        .o_found         (o_found),
        .o_fill_level    (o_fill_level),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [DATA_W-1:0] pick_word();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        if (roll < 3 && pushed_words.size() > 0)
            return pushed_words[$urandom_range(0, pushed_words.size() - 1)];
        return $urandom;
    endfunction

    // Random stall on the result side.
    always @(posedge i_clk) begin
        if (pop_hold > 0) begin
            pop_hold <= pop_hold - 1;
            pop      <= 1'b0;
        end else begin
            pop <= 1'b1;
            if ($urandom_range(0, 9) == 0) pop_hold <= pick_gap();
        end
    end

    // Watchdog: end the run when no transaction moves for too long.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic issue_command(t_op op, logic [DATA_W-1:0] word, bit no_gaps);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_cmd  <= op;
        i_data <= word;
        do @(posedge i_clk); while (full);
        if (op == OP_PUSH) begin
            pushed_words.push_back(word);
            if (pushed_words.size() > 32) void'(pushed_words.pop_front());
        end
    endtask

    // Drain every pending result, let the back end settle, then write capacity.
    task automatic write_capacity(logic [CAP_W-1:0] cap);
        push <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= cap;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic run_random_phase(logic [CAP_W-1:0] cap, int push_bias);
        bit no_gaps;
        int roll;
        write_capacity(cap);
        no_gaps = ($urandom_range(0, 3) == 0);
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < push_bias)
                issue_command(OP_PUSH, pick_word(), no_gaps);
            else if (roll < push_bias + (100 - push_bias) * 4 / 10)
                issue_command(OP_POP, pick_word(), no_gaps);
            else if (roll < push_bias + (100 - push_bias) * 6 / 10)
                issue_command(OP_PEEK, pick_word(), no_gaps);
            else if ($urandom_range(0, 9) < 6 && pushed_words.size() > 0)
                issue_command(OP_SEARCH,
                              pushed_words[$urandom_range(0, pushed_words.size() - 1)],
                              no_gaps);
            else
                issue_command(OP_SEARCH, pick_word(), no_gaps);
        end
    endtask

    initial begin
        logic [CAP_W-1:0] phase_caps [12];
        phase_caps = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd7, 5'd16, 5'd17, 5'd3,
                       5'd30, 5'd16, 5'd2, 5'd12};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // refused on an empty stack
        issue_command(OP_POP, 32'h0, 1'b0);
        issue_command(OP_PEEK, 32'h0, 1'b0);
        issue_command(OP_SEARCH, 32'h0, 1'b0);
        // extremes of the data word
        issue_command(OP_PUSH, 32'h8000_0000, 1'b0);
        issue_command(OP_PUSH, 32'h7FFF_FFFF, 1'b0);
        issue_command(OP_PUSH, 32'h0000_0000, 1'b0);
        issue_command(OP_PUSH, 32'hFFFF_FFFF, 1'b0);
        issue_command(OP_PEEK, 32'h0, 1'b0);
        issue_command(OP_SEARCH, 32'h8000_0000, 1'b0);
        issue_command(OP_SEARCH, 32'h0000_3039, 1'b0);
        issue_command(OP_POP, 32'h0, 1'b0);
        // popped word is stale and must not match
        issue_command(OP_SEARCH, 32'hFFFF_FFFF, 1'b0);
        issue_command(OP_POP, 32'h0, 1'b0);

        // capacity below the fill level keeps entries but refuses pushes
        write_capacity(5'd1);
        issue_command(OP_PUSH, 32'h1234_5678, 1'b0);
        issue_command(OP_POP, 32'h0, 1'b0);
        issue_command(OP_PUSH, 32'h5555_AAAA, 1'b0);
        issue_command(OP_POP, 32'h0, 1'b0);
        issue_command(OP_PUSH, 32'hAAAA_5555, 1'b0);

        // zero capacity refuses every push
        write_capacity(5'd0);
        issue_command(OP_PUSH, 32'h0BAD_F00D, 1'b0);
        issue_command(OP_POP, 32'h0, 1'b0);

        for (int p = 0; p < 12; p++)
            run_random_phase(phase_caps[p], (p % 2 == 0) ? $urandom_range(60, 75)
                                                         : $urandom_range(25, 40));

        push <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
